// File: rtl/core/hex20_shape_function_eval_defines.svh
// ----------------------------------------------------------------------------
// hex20 shape function evaluator: assertion macros
// Concurrent assertion wrappers, clocked on clk_i, removable with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef HEX20_SHAPE_FUNCTION_EVAL_DEFINES_SVH
`define HEX20_SHAPE_FUNCTION_EVAL_DEFINES_SVH

`ifndef ASSERT_OFF
// checked outside reset only
`define H20SF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked during reset as well
`define H20SF_ASSERT_NR(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define H20SF_ASSERT(name, prop, msg)
`define H20SF_ASSERT_NR(name, prop, msg)
`endif

`endif

// File: rtl/core/h20sf_pkg.sv
// ----------------------------------------------------------------------------
// h20sf_pkg
// Types, constants and node table of the 20-node serendipity brick evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package h20sf_pkg;

  localparam int unsigned FracBits = 14;
  localparam int unsigned CoordW   = 16;
  localparam int unsigned NumNodes = 20;
  localparam int unsigned IdxW     = 5;
  localparam int unsigned ResW     = 17;
  localparam int unsigned NumLanes = 4;

  // clamped coordinate, signed, [-1,1]
  localparam int unsigned GW   = FracBits + 2;
  // linear factor 1 +/- g, unsigned, [0,2]
  localparam int unsigned LinW = FracBits + 2;
  // last factor magnitude, unsigned, up to 5
  localparam int unsigned M3W  = FracBits + 3;
  // signed sums of coordinates, [-5,3]
  localparam int unsigned SumW = FracBits + 4;
  localparam int unsigned PW   = 2 * LinW;
  localparam int unsigned QW   = 3 * LinW;
  localparam int unsigned RW   = 3 * LinW + M3W;
  localparam int unsigned ShW  = 7;

  // last multiply works on the two halves of the three-factor product
  localparam int unsigned HalfQW = QW / 2;
  localparam int unsigned PartW  = HalfQW + M3W;

  localparam logic [IdxW-1:0] LastNode = IdxW'(NumNodes - 1);

  localparam logic signed [SumW-1:0] OneS = SumW'(2 ** FracBits);
  localparam logic signed [SumW-1:0] TwoS = SumW'(2 ** (FracBits + 1));

  // rounding shift = factors * frac + scale exponent - frac
  localparam logic [ShW-1:0] ShCornerVal = ShW'(3 * FracBits + 3);
  localparam logic [ShW-1:0] ShMidVal    = ShW'(3 * FracBits + 2);
  localparam logic [ShW-1:0] ShCornerDer = ShW'(2 * FracBits + 3);
  localparam logic [ShW-1:0] ShMidDer    = ShW'(2 * FracBits + 2);
  localparam logic [ShW-1:0] ShMidDerZ   = ShW'(2 * FracBits + 1);

  localparam int MagMaxPos = 2 ** (ResW - 1) - 1;
  localparam int MagMaxNeg = 2 ** (ResW - 1);
  localparam logic signed [ResW-1:0] SatMax = ResW'(MagMaxPos);
  localparam logic signed [ResW-1:0] SatMin = ResW'(MagMaxNeg);

  localparam logic signed [1:0] NcNeg  = 2'sb11;
  localparam logic signed [1:0] NcZero = 2'sb00;
  localparam logic signed [1:0] NcPos  = 2'sb01;

  typedef struct packed {
    logic signed [1:0] r;
    logic signed [1:0] s;
    logic signed [1:0] t;
  } node_t;

  typedef struct packed {
    logic            neg;
    logic [ShW-1:0]  sh;
  } lane_meta_t;

  typedef struct packed {
    logic [LinW-1:0] m0;
    logic [LinW-1:0] m1;
    logic [LinW-1:0] m2;
    logic [M3W-1:0]  m3;
    lane_meta_t      meta;
  } lane_t;

  function automatic node_t node_coord(logic [IdxW-1:0] idx);
    node_t n;
    unique case (idx)
      IdxW'(0):  n = '{NcNeg,  NcNeg,  NcNeg};
      IdxW'(1):  n = '{NcPos,  NcNeg,  NcNeg};
      IdxW'(2):  n = '{NcPos,  NcPos,  NcNeg};
      IdxW'(3):  n = '{NcNeg,  NcPos,  NcNeg};
      IdxW'(4):  n = '{NcNeg,  NcNeg,  NcPos};
      IdxW'(5):  n = '{NcPos,  NcNeg,  NcPos};
      IdxW'(6):  n = '{NcPos,  NcPos,  NcPos};
      IdxW'(7):  n = '{NcNeg,  NcPos,  NcPos};
      IdxW'(8):  n = '{NcZero, NcNeg,  NcNeg};
      IdxW'(9):  n = '{NcPos,  NcZero, NcNeg};
      IdxW'(10): n = '{NcZero, NcPos,  NcNeg};
      IdxW'(11): n = '{NcNeg,  NcZero, NcNeg};
      IdxW'(12): n = '{NcNeg,  NcNeg,  NcZero};
      IdxW'(13): n = '{NcPos,  NcNeg,  NcZero};
      IdxW'(14): n = '{NcPos,  NcPos,  NcZero};
      IdxW'(15): n = '{NcNeg,  NcPos,  NcZero};
      IdxW'(16): n = '{NcZero, NcNeg,  NcPos};
      IdxW'(17): n = '{NcPos,  NcZero, NcPos};
      IdxW'(18): n = '{NcZero, NcPos,  NcPos};
      IdxW'(19): n = '{NcNeg,  NcZero, NcPos};
      default:   n = '{NcZero, NcZero, NcZero};
    endcase
    return n;
  endfunction

  function automatic logic signed [GW-1:0] clamp_coord(logic signed [CoordW-1:0] x);
    int xi;
    int one;
    xi  = int'(x);
    one = 2 ** FracBits;
    if (xi > one) begin
      xi = one;
    end else if (xi < -one) begin
      xi = -one;
    end
    return GW'(xi);
  endfunction

endpackage

// File: rtl/core/hex20_shape_function_eval.sv
// ----------------------------------------------------------------------------
// hex20_shape_function_eval
// Shape functions and derivatives of the 20-node serendipity brick at a point.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                          tuser  tlast
//  s_axis    in   coord_r, coord_s, coord_t      -      -
//  m_axis    out  node_index .. deriv_t          -      last_node
//
//  One point in gives twenty node items out, one item per cycle while the
//  output is taken; the node sequencer sets that, and takes the next point
//  as the last node issues. Items leave through a 7-stage chain of factor
//  setup, three multiplies, rounding and saturation.
//  Reset clears the sequencer and the stage valid bits; no clearing pass.
//  A held output freezes the whole chain; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hex20_shape_function_eval_defines.svh"

module hex20_shape_function_eval
  import h20sf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] coord_r, [31:16] coord_s, [47:32] coord_t
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [4:0] node_index, [6:5] node_r, [8:7] node_s, [10:9] node_t,
  // [27:11] shape_value, [44:28] deriv_r, [61:45] deriv_s, [78:62] deriv_t, [79] zero
  output logic [79:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  // sequencer
  logic                   busy_q;
  logic [IdxW-1:0]        cnt_q;
  logic signed [GW-1:0]   point_q [3];
  logic                   adv;
  logic                   accept;

  // stage valid bits, stages 1..6
  logic [5:0]             vld_q;
  logic                   out_valid_q;

  // stage 1
  logic [IdxW-1:0]        idx1_q;
  logic signed [GW-1:0]   g1_q [3];
  logic [LinW-1:0]        lp1_q [3];
  logic [LinW-1:0]        lm1_q [3];
  // stage 2
  logic [IdxW-1:0]        idx2_q;
  lane_t                  lane2_q [NumLanes];
  lane_t                  lane2_d [NumLanes];
  // stage 3
  logic [IdxW-1:0]        idx3_q;
  logic [PW-1:0]          p3_q [NumLanes];
  logic [LinW-1:0]        m2_3_q [NumLanes];
  logic [M3W-1:0]         m3_3_q [NumLanes];
  lane_meta_t             meta3_q [NumLanes];
  // stage 4
  logic [IdxW-1:0]        idx4_q;
  logic [QW-1:0]          q4_q [NumLanes];
  logic [M3W-1:0]         m3_4_q [NumLanes];
  lane_meta_t             meta4_q [NumLanes];
  // stage 5
  logic [IdxW-1:0]        idx5_q;
  logic [PartW-1:0]       r5_lo_q [NumLanes];
  logic [PartW-1:0]       r5_hi_q [NumLanes];
  lane_meta_t             meta5_q [NumLanes];
  // stage 6
  logic [IdxW-1:0]        idx6_q;
  logic [RW-1:0]          r6_q [NumLanes];
  lane_meta_t             meta6_q [NumLanes];
  // output
  logic [IdxW-1:0]        out_idx_q;
  node_t                  out_node_q;
  logic signed [ResW-1:0] out_res_q [NumLanes];
  logic                   out_last_q;

  function automatic logic [M3W-1:0] mag_of(logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] a;
    a = v[SumW-1] ? -v : v;
    return M3W'(a);
  endfunction

  function automatic logic signed [ResW-1:0] saturate(logic [RW-1:0] r, lane_meta_t m);
    logic [RW-1:0]          mag;
    logic signed [ResW-1:0] res;
    mag = r >> m.sh;
    if (m.neg) begin
      if (mag > RW'(MagMaxNeg)) begin
        res = SatMin;
      end else begin
        res = -$signed(ResW'(mag));
      end
    end else begin
      if (mag > RW'(MagMaxPos)) begin
        res = SatMax;
      end else begin
        res = $signed(ResW'(mag));
      end
    end
    return res;
  endfunction

  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !busy_q || (adv && (cnt_q == LastNode));
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // node sequencer and valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (adv && busy_q) begin
        if (cnt_q == LastNode) begin
          busy_q <= 1'b0;
          cnt_q  <= '0;
        end else begin
          cnt_q <= cnt_q + IdxW'(1);
        end
      end
      if (adv) begin
        vld_q       <= {vld_q[4:0], busy_q};
        out_valid_q <= vld_q[5];
      end
    end
  end

  // lane factors: value lane 0, derivative lanes 1..3 along r, s, t
  always_comb begin : s2_comb
    node_t                  nd;
    logic signed [1:0]      nv [3];
    logic signed [SumW-1:0] gs [3];
    logic signed [SumW-1:0] ng [3];
    logic [LinW-1:0]        lin [3];
    logic signed [SumW-1:0] dot;
    logic signed [SumW-1:0] f3;
    logic signed [SumW-1:0] f2;
    logic signed [SumW-1:0] gz;
    logic [LinW-1:0]        gz_mag;
    logic                   corner;
    logic [1:0]             z;
    logic [1:0]             za;
    logic [1:0]             zc;
    logic [1:0]             o;
    int                     a;
    int                     c;

    nd    = node_coord(idx1_q);
    nv[0] = nd.r;
    nv[1] = nd.s;
    nv[2] = nd.t;
    for (int d = 0; d < 3; d++) begin
      gs[d] = SumW'(g1_q[d]);
      if (nv[d] == NcPos) begin
        ng[d]  = gs[d];
        lin[d] = lp1_q[d];
      end else if (nv[d] == NcNeg) begin
        ng[d]  = -gs[d];
        lin[d] = lm1_q[d];
      end else begin
        ng[d]  = '0;
        lin[d] = lm1_q[d];
      end
    end
    dot    = ng[0] + ng[1] + ng[2];
    f3     = dot - TwoS;
    corner = (nv[0] != NcZero) && (nv[1] != NcZero) && (nv[2] != NcZero);
    if (nv[0] == NcZero) begin
      z = 2'd0;
    end else if (nv[1] == NcZero) begin
      z = 2'd1;
    end else begin
      z = 2'd2;
    end
    za     = (z == 2'd0) ? 2'd1 : 2'd0;
    zc     = (z == 2'd2) ? 2'd1 : 2'd2;
    gz     = gs[z];
    gz_mag = gz[SumW-1] ? LinW'(-gz) : LinW'(gz);

    if (corner) begin
      lane2_d[0].m0       = lin[0];
      lane2_d[0].m1       = lin[1];
      lane2_d[0].m2       = lin[2];
      lane2_d[0].m3       = mag_of(f3);
      lane2_d[0].meta.neg = f3[SumW-1];
      lane2_d[0].meta.sh  = ShCornerVal;
    end else begin
      lane2_d[0].m0       = lm1_q[z];
      lane2_d[0].m1       = lp1_q[z];
      lane2_d[0].m2       = lin[za];
      lane2_d[0].m3       = M3W'(lin[zc]);
      lane2_d[0].meta.neg = 1'b0;
      lane2_d[0].meta.sh  = ShMidVal;
    end

    for (int d = 0; d < 3; d++) begin
      a  = (d == 2) ? 0 : d + 1;
      c  = (d == 0) ? 2 : d - 1;
      f2 = ng[d] + dot - OneS;
      o  = 2'(3 - d - int'(z));
      if (corner) begin
        lane2_d[d+1].m0       = lin[a];
        lane2_d[d+1].m1       = lin[c];
        lane2_d[d+1].m2       = LinW'(1);
        lane2_d[d+1].m3       = mag_of(f2);
        lane2_d[d+1].meta.neg = (nv[d] == NcNeg) ^ f2[SumW-1];
        lane2_d[d+1].meta.sh  = ShCornerDer;
      end else if (z == 2'(d)) begin
        // derivative across the quadratic axis: -2 g (1-..)(1-..) / 4
        lane2_d[d+1].m0       = gz_mag;
        lane2_d[d+1].m1       = lin[za];
        lane2_d[d+1].m2       = lin[zc];
        lane2_d[d+1].m3       = M3W'(1);
        lane2_d[d+1].meta.neg = ~gz[SumW-1];
        lane2_d[d+1].meta.sh  = ShMidDerZ;
      end else begin
        lane2_d[d+1].m0       = lm1_q[z];
        lane2_d[d+1].m1       = lp1_q[z];
        lane2_d[d+1].m2       = lin[o];
        lane2_d[d+1].m3       = M3W'(1);
        lane2_d[d+1].meta.neg = (nv[d] == NcNeg);
        lane2_d[d+1].meta.sh  = ShMidDer;
      end
    end
  end

  // payload path, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      point_q[0] <= clamp_coord(s_axis_tdata_i[CoordW-1:0]);
      point_q[1] <= clamp_coord(s_axis_tdata_i[2*CoordW-1:CoordW]);
      point_q[2] <= clamp_coord(s_axis_tdata_i[3*CoordW-1:2*CoordW]);
    end
    if (adv) begin
      idx1_q <= cnt_q;
      for (int d = 0; d < 3; d++) begin
        g1_q[d]  <= point_q[d];
        lp1_q[d] <= LinW'(OneS + SumW'(point_q[d]));
        lm1_q[d] <= LinW'(OneS - SumW'(point_q[d]));
      end

      idx2_q <= idx1_q;
      idx3_q <= idx2_q;
      idx4_q <= idx3_q;
      idx5_q <= idx4_q;
      idx6_q <= idx5_q;
      for (int l = 0; l < NumLanes; l++) begin
        lane2_q[l] <= lane2_d[l];

        p3_q[l]    <= PW'(lane2_q[l].m0) * PW'(lane2_q[l].m1);
        m2_3_q[l]  <= lane2_q[l].m2;
        m3_3_q[l]  <= lane2_q[l].m3;
        meta3_q[l] <= lane2_q[l].meta;

        q4_q[l]    <= QW'(p3_q[l]) * QW'(m2_3_q[l]);
        m3_4_q[l]  <= m3_3_q[l];
        meta4_q[l] <= meta3_q[l];

        // last factor times each half of the product, summed in the next stage
        r5_lo_q[l] <= PartW'(q4_q[l][HalfQW-1:0]) * PartW'(m3_4_q[l]);
        r5_hi_q[l] <= PartW'(q4_q[l][QW-1:HalfQW]) * PartW'(m3_4_q[l]);
        meta5_q[l] <= meta4_q[l];

        // half an output step, ties go away from zero on the magnitude
        r6_q[l]    <= RW'(r5_lo_q[l]) + (RW'(r5_hi_q[l]) << HalfQW)
                      + (RW'(1) << (meta5_q[l].sh - ShW'(1)));
        meta6_q[l] <= meta5_q[l];

        out_res_q[l] <= saturate(r6_q[l], meta6_q[l]);
      end
      out_idx_q  <= idx6_q;
      out_node_q <= node_coord(idx6_q);
      out_last_q <= (idx6_q == LastNode);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {1'b0, out_res_q[3], out_res_q[2], out_res_q[1], out_res_q[0],
                            out_node_q.t, out_node_q.s, out_node_q.r, out_idx_q};

  `H20SF_ASSERT_NR(a_idle_cnt_zero, !busy_q |-> (cnt_q == '0), "node counter not cleared while idle")
  `H20SF_ASSERT(a_cnt_range, busy_q |-> (cnt_q <= LastNode), "node counter past last node")
  `H20SF_ASSERT(a_accept_at_end, (accept && busy_q) |-> (adv && (cnt_q == LastNode)), "point taken before previous one issued")
  `H20SF_ASSERT(a_stall_freezes, !adv |=> $stable(cnt_q), "sequencer moved during a stall")
  `H20SF_ASSERT(a_last_matches, out_valid_q |-> (out_last_q == (out_idx_q == LastNode)), "last flag on wrong node")

endmodule
